>>> rtl/mfsp_pkg.sv
`timescale 1ns / 1ps
package mfsp_pkg;

    localparam logic [3:0] KIND_HEADER  = 4'd0;
    localparam logic [3:0] KIND_CHANNEL = 4'd1;
    localparam logic [3:0] KIND_META    = 4'd2;
    localparam logic [3:0] KIND_SYSEX   = 4'd3;
    localparam logic [3:0] KIND_SYSTEM  = 4'd4;
    localparam logic [3:0] KIND_PAYLOAD = 4'd5;
    localparam logic [3:0] KIND_TRKEND  = 4'd6;
    localparam logic [3:0] KIND_ERROR   = 4'd7;
    localparam logic [3:0] KIND_DONE    = 4'd8;

    localparam logic [31:0] ERR_SMALL      = 32'd0;
    localparam logic [31:0] ERR_NO_MTHD    = 32'd1;
    localparam logic [31:0] ERR_HDR_LEN    = 32'd2;
    localparam logic [31:0] ERR_TRK_HDR    = 32'd3;
    localparam logic [31:0] ERR_NO_MTRK    = 32'd4;
    localparam logic [31:0] ERR_TRK_DATA   = 32'd5;
    localparam logic [31:0] ERR_DELTA      = 32'd6;
    localparam logic [31:0] ERR_END_DELTA  = 32'd7;
    localparam logic [31:0] ERR_NO_RUNNING = 32'd8;
    localparam logic [31:0] ERR_META_TYPE  = 32'd9;
    localparam logic [31:0] ERR_META_LEN   = 32'd10;
    localparam logic [31:0] ERR_SYSEX_LEN  = 32'd11;
    localparam logic [31:0] ERR_DATA1      = 32'd12;
    localparam logic [31:0] ERR_DATA2      = 32'd13;
    localparam logic [31:0] ERR_SYSTEM     = 32'd14;

    localparam logic [3:0] MIN_FILE_BYTES = 4'd14;
    localparam int unsigned MAX_RECS = 4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] track;
        logic [31:0] tick;
        logic [27:0] delta;
        logic [7:0]  status;
        logic [7:0]  meta;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [31:0] count;
        logic [15:0] fmt;
        logic [15:0] div;
    } t_rec;

    typedef struct packed {
        t_rec [MAX_RECS-1:0] recs;
        logic [2:0]          nrec;
    } t_batch;

    function automatic logic [7:0] hdr_magic(input logic [1:0] idx);
        case (idx)
            2'd0: hdr_magic = 8'h4D;
            2'd1: hdr_magic = 8'h54;
            2'd2: hdr_magic = 8'h68;
            default: hdr_magic = 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] trk_magic(input logic [1:0] idx);
        case (idx)
            2'd0: trk_magic = 8'h4D;
            2'd1: trk_magic = 8'h54;
            2'd2: trk_magic = 8'h72;
            default: trk_magic = 8'h6B;
        endcase
    endfunction

endpackage

>>> rtl/mfsp_if.sv
`timescale 1ns / 1ps
interface mfsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_file;
    modport source (output valid, byte_value, end_of_file, input ready);
    modport sink (input valid, byte_value, end_of_file, output ready);
endinterface

interface mfsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  record_kind;
    logic        run_end;
    logic [15:0] track_number;
    logic [31:0] tick_time;
    logic [27:0] delta_ticks;
    logic [7:0]  status_byte;
    logic [7:0]  meta_kind;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [31:0] count_or_code;
    logic [15:0] file_format;
    logic [15:0] time_division;
    modport source (output valid, record_kind, run_end, track_number, tick_time, delta_ticks,
                    status_byte, meta_kind, first_data, second_data, count_or_code,
                    file_format, time_division, input ready);
    modport sink (input valid, record_kind, run_end, track_number, tick_time, delta_ticks,
                  status_byte, meta_kind, first_data, second_data, count_or_code,
                  file_format, time_division, output ready);
endinterface

>>> rtl/mfsp_parser.sv
`timescale 1ns / 1ps
module mfsp_parser import mfsp_pkg::*; #(
    parameter int VLQ_MAX_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_eof,
    output t_batch     o_batch
);

    localparam logic [3:0] PH_MAGIC    = 4'd0;
    localparam logic [3:0] PH_HLEN     = 4'd1;
    localparam logic [3:0] PH_HWORDS   = 4'd2;
    localparam logic [3:0] PH_HSKIP    = 4'd3;
    localparam logic [3:0] PH_TMAGIC   = 4'd4;
    localparam logic [3:0] PH_TLEN     = 4'd5;
    localparam logic [3:0] PH_DELTA    = 4'd6;
    localparam logic [3:0] PH_STATUS   = 4'd7;
    localparam logic [3:0] PH_METATYPE = 4'd8;
    localparam logic [3:0] PH_METALEN  = 4'd9;
    localparam logic [3:0] PH_SXLEN    = 4'd10;
    localparam logic [3:0] PH_DATA1    = 4'd11;
    localparam logic [3:0] PH_DATA2    = 4'd12;
    localparam logic [3:0] PH_PAYLOAD  = 4'd13;
    localparam logic [3:0] PH_DONE     = 4'd14;
    localparam logic [3:0] PH_ERROR    = 4'd15;

    localparam logic [2:0] VLQ_LIMIT = 3'(VLQ_MAX_BYTES);

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_cbi, n_cbi;
    logic [3:0]  r_fbs, n_fbs;
    logic [31:0] r_hleft, n_hleft;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_div, n_div;
    logic [15:0] r_ttot, n_ttot;
    logic [15:0] r_tdone, n_tdone;
    logic [31:0] r_tleft, n_tleft;
    logic [31:0] r_tick, n_tick;
    logic [27:0] r_vlq, n_vlq;
    logic [2:0]  r_vlqn, n_vlqn;
    logic [7:0]  r_rs, n_rs;
    logic [7:0]  r_es, n_es;
    logic [7:0]  r_meta, n_meta;
    logic [7:0]  r_pend, n_pend;
    logic [31:0] r_pleft, n_pleft;
    logic [27:0] r_edelta, n_edelta;

    t_rec [MAX_RECS-1:0] v_recs;
    logic [2:0]          v_n;

    function automatic t_rec mk_rec(input logic [3:0] kind);
        t_rec r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    always_comb begin
        logic        do_hdr;
        logic        do_finish;
        logic        do_done;
        logic        v_done;
        logic        v_long;
        logic [31:0] v_err;
        logic [31:0] v_len;
        logic [7:0]  v_cls;
        t_rec        rec;

        n_phase = r_phase;  n_cbi = r_cbi;    n_fbs = r_fbs;    n_hleft = r_hleft;
        n_fmt = r_fmt;      n_div = r_div;    n_ttot = r_ttot;  n_tdone = r_tdone;
        n_tleft = r_tleft;  n_tick = r_tick;  n_vlq = r_vlq;    n_vlqn = r_vlqn;
        n_rs = r_rs;        n_es = r_es;      n_meta = r_meta;  n_pend = r_pend;
        n_pleft = r_pleft;  n_edelta = r_edelta;
        v_recs = '0;
        v_n = 3'd0;
        do_hdr = 1'b0;
        do_finish = 1'b0;
        do_done = 1'b0;
        v_done = 1'b0;
        v_long = 1'b0;
        v_err = '0;
        v_len = '0;
        v_cls = i_byte & 8'hF0;
        rec = '0;

        if (r_fbs < MIN_FILE_BYTES) begin
            n_fbs = r_fbs + 4'd1;
        end

        case (r_phase)
            PH_MAGIC: begin
                if (i_byte != hdr_magic(r_cbi[1:0])) begin
                    v_err = ERR_NO_MTHD;
                end else if (r_cbi == 3'd3) begin
                    n_cbi = 3'd0;
                    n_hleft = '0;
                    n_phase = PH_HLEN;
                end else begin
                    n_cbi = r_cbi + 3'd1;
                end
            end
            PH_HLEN: begin
                n_hleft = {r_hleft[23:0], i_byte};
                if (r_cbi == 3'd3) begin
                    n_cbi = 3'd0;
                    if (n_hleft < 32'd6) begin
                        v_err = ERR_HDR_LEN;
                    end else begin
                        n_hleft = n_hleft - 32'd6;
                        n_phase = PH_HWORDS;
                    end
                end else begin
                    n_cbi = r_cbi + 3'd1;
                end
            end
            PH_HWORDS: begin
                if (r_cbi < 3'd2) begin
                    n_fmt = {r_fmt[7:0], i_byte};
                end else if (r_cbi < 3'd4) begin
                    n_ttot = {r_ttot[7:0], i_byte};
                end else begin
                    n_div = {r_div[7:0], i_byte};
                end
                if (r_cbi == 3'd5) begin
                    n_cbi = 3'd0;
                    if (r_hleft == '0) begin
                        do_hdr = 1'b1;
                    end else begin
                        n_phase = PH_HSKIP;
                    end
                end else begin
                    n_cbi = r_cbi + 3'd1;
                end
            end
            PH_HSKIP: begin
                n_hleft = r_hleft - 32'd1;
                if (n_hleft == '0) begin
                    do_hdr = 1'b1;
                end
            end
            PH_TMAGIC: begin
                if (i_byte != trk_magic(r_cbi[1:0])) begin
                    v_err = ERR_NO_MTRK;
                end else if (r_cbi == 3'd3) begin
                    n_cbi = 3'd0;
                    n_tleft = '0;
                    n_phase = PH_TLEN;
                end else begin
                    n_cbi = r_cbi + 3'd1;
                end
            end
            PH_TLEN: begin
                n_tleft = {r_tleft[23:0], i_byte};
                if (r_cbi == 3'd3) begin
                    n_cbi = 3'd0;
                    n_tick = '0;
                    n_rs = '0;
                    n_edelta = '0;
                    n_vlq = '0;
                    n_vlqn = '0;
                    if (n_tleft == '0) begin
                        do_finish = 1'b1;
                    end else begin
                        n_phase = PH_DELTA;
                    end
                end else begin
                    n_cbi = r_cbi + 3'd1;
                end
            end
            PH_DONE, PH_ERROR: begin
            end
            default: begin
                // Track body: every byte counts against the chunk length.
                n_tleft = r_tleft - 32'd1;
                if (r_phase == PH_DELTA || r_phase == PH_METALEN || r_phase == PH_SXLEN) begin
                    n_vlq = {r_vlq[20:0], i_byte[6:0]};
                    n_vlqn = r_vlqn + 3'd1;
                    v_done = !i_byte[7];
                    v_long = i_byte[7] && (n_vlqn >= VLQ_LIMIT);
                end
                case (r_phase)
                    PH_DELTA: begin
                        if (v_long) begin
                            v_err = ERR_DELTA;
                        end else if (v_done) begin
                            n_edelta = n_vlq;
                            n_tick = r_tick + {4'd0, n_vlq};
                            n_vlq = '0;
                            n_vlqn = '0;
                            n_phase = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        if (!i_byte[7]) begin
                            if (r_rs == '0) begin
                                v_err = ERR_NO_RUNNING;
                            end else begin
                                n_es = r_rs;
                                n_pend = i_byte;
                                n_phase = PH_DATA1;
                            end
                        end else begin
                            n_es = i_byte;
                            if (i_byte == 8'hFF) begin
                                n_phase = PH_METATYPE;
                            end else if (i_byte == 8'hF0 || i_byte == 8'hF7) begin
                                n_vlq = '0;
                                n_vlqn = '0;
                                n_phase = PH_SXLEN;
                            end else if (v_cls <= 8'hE0) begin
                                n_rs = i_byte;
                                n_phase = PH_DATA1;
                            end else begin
                                n_rs = '0;
                                if (i_byte == 8'hF1 || i_byte == 8'hF3) begin
                                    v_len = 32'd1;
                                end else if (i_byte == 8'hF2) begin
                                    v_len = 32'd2;
                                end
                                if (v_len > n_tleft) begin
                                    v_err = ERR_SYSTEM;
                                end else begin
                                    rec = mk_rec(KIND_SYSTEM);
                                    rec.track = r_tdone;
                                    rec.tick = r_tick;
                                    rec.delta = r_edelta;
                                    rec.status = i_byte;
                                    rec.count = v_len;
                                    v_recs[v_n[1:0]] = rec;
                                    v_n = v_n + 3'd1;
                                    n_pleft = v_len;
                                    if (v_len == '0) begin
                                        n_vlq = '0;
                                        n_vlqn = '0;
                                        n_phase = PH_DELTA;
                                    end else begin
                                        n_phase = PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                    end
                    PH_METATYPE: begin
                        n_meta = i_byte;
                        n_vlq = '0;
                        n_vlqn = '0;
                        n_phase = PH_METALEN;
                    end
                    PH_METALEN, PH_SXLEN: begin
                        v_err = (r_phase == PH_METALEN) ? ERR_META_LEN : ERR_SYSEX_LEN;
                        v_len = {4'd0, n_vlq};
                        if (!v_long && !(v_done && v_len > n_tleft)) begin
                            v_err = '0;
                        end
                        if (!v_long && v_done && v_len <= n_tleft) begin
                            rec = mk_rec((r_phase == PH_METALEN) ? KIND_META : KIND_SYSEX);
                            rec.track = r_tdone;
                            rec.tick = r_tick;
                            rec.delta = r_edelta;
                            rec.status = r_es;
                            rec.count = v_len;
                            rec.meta = (r_phase == PH_METALEN) ? r_meta : 8'd0;
                            v_recs[v_n[1:0]] = rec;
                            v_n = v_n + 3'd1;
                            n_pleft = v_len;
                            if (v_len == '0) begin
                                n_vlq = '0;
                                n_vlqn = '0;
                                n_phase = PH_DELTA;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                        if (v_long || (v_done && v_len > n_tleft)) begin
                            v_err = (r_phase == PH_METALEN) ? ERR_META_LEN : ERR_SYSEX_LEN;
                        end else begin
                            v_err = '0;
                        end
                    end
                    PH_DATA1: begin
                        n_pend = i_byte;
                        n_phase = PH_DATA1;
                    end
                    PH_DATA2: begin
                        rec = mk_rec(KIND_CHANNEL);
                        rec.track = r_tdone;
                        rec.tick = r_tick;
                        rec.delta = r_edelta;
                        rec.status = r_es;
                        rec.d1 = r_pend;
                        rec.d2 = i_byte;
                        v_recs[v_n[1:0]] = rec;
                        v_n = v_n + 3'd1;
                        n_vlq = '0;
                        n_vlqn = '0;
                        n_phase = PH_DELTA;
                    end
                    default: begin
                        rec = mk_rec(KIND_PAYLOAD);
                        rec.track = r_tdone;
                        rec.tick = r_tick;
                        rec.delta = r_edelta;
                        rec.status = r_es;
                        rec.d1 = i_byte;
                        v_recs[v_n[1:0]] = rec;
                        v_n = v_n + 3'd1;
                        n_pleft = r_pleft - 32'd1;
                        if (n_pleft == '0) begin
                            n_vlq = '0;
                            n_vlqn = '0;
                            n_phase = PH_DELTA;
                        end
                    end
                endcase
                // A data byte just taken: program change and channel pressure end here.
                if (v_err == '0 && n_phase == PH_DATA1 &&
                    (r_phase == PH_DATA1 || r_phase == PH_STATUS) && n_pend == i_byte &&
                    !(r_phase == PH_STATUS && i_byte[7])) begin
                    if ((n_es & 8'hF0) == 8'hC0 || (n_es & 8'hF0) == 8'hD0) begin
                        rec = mk_rec(KIND_CHANNEL);
                        rec.track = r_tdone;
                        rec.tick = r_tick;
                        rec.delta = r_edelta;
                        rec.status = n_es;
                        rec.d1 = i_byte;
                        v_recs[v_n[1:0]] = rec;
                        v_n = v_n + 3'd1;
                        n_vlq = '0;
                        n_vlqn = '0;
                        n_phase = PH_DELTA;
                    end else begin
                        n_phase = PH_DATA2;
                    end
                end
                // Last byte of the chunk: close the track or report the open event.
                if (v_err == '0 && n_tleft == '0) begin
                    case (n_phase)
                        PH_DELTA:    begin
                            if (n_vlqn == '0) begin
                                do_finish = 1'b1;
                            end else begin
                                v_err = ERR_DELTA;
                            end
                        end
                        PH_STATUS:   v_err = ERR_END_DELTA;
                        PH_METATYPE: v_err = ERR_META_TYPE;
                        PH_METALEN:  v_err = ERR_META_LEN;
                        PH_SXLEN:    v_err = ERR_SYSEX_LEN;
                        PH_DATA1:    v_err = ERR_DATA1;
                        PH_DATA2:    v_err = ERR_DATA2;
                        default:     v_err = ERR_TRK_DATA;
                    endcase
                end
            end
        endcase

        // Error code zero is "file too small", which only the end-of-file check raises,
        // so zero here means no error on this byte.
        if (v_err != '0) begin
            rec = mk_rec(KIND_ERROR);
            rec.track = n_tdone;
            rec.count = v_err;
            v_recs[v_n[1:0]] = rec;
            v_n = v_n + 3'd1;
            n_phase = PH_ERROR;
        end

        if (do_hdr) begin
            rec = mk_rec(KIND_HEADER);
            rec.count = {16'd0, n_ttot};
            rec.fmt = n_fmt;
            rec.div = n_div;
            v_recs[v_n[1:0]] = rec;
            v_n = v_n + 3'd1;
            if (n_ttot == '0) begin
                do_done = 1'b1;
            end else begin
                n_phase = PH_TMAGIC;
                n_cbi = 3'd0;
            end
        end

        if (do_finish) begin
            rec = mk_rec(KIND_TRKEND);
            rec.track = n_tdone;
            rec.tick = n_tick;
            v_recs[v_n[1:0]] = rec;
            v_n = v_n + 3'd1;
            n_tdone = n_tdone + 16'd1;
            if (n_tdone == n_ttot) begin
                do_done = 1'b1;
            end else begin
                n_phase = PH_TMAGIC;
                n_cbi = 3'd0;
                n_tleft = '0;
            end
        end

        if (do_done) begin
            rec = mk_rec(KIND_DONE);
            rec.count = {16'd0, n_ttot};
            v_recs[v_n[1:0]] = rec;
            v_n = v_n + 3'd1;
            n_phase = PH_DONE;
        end

        if (i_eof) begin
            if (n_phase != PH_DONE && n_phase != PH_ERROR) begin
                rec = mk_rec(KIND_ERROR);
                rec.track = n_tdone;
                if (n_fbs < MIN_FILE_BYTES) begin
                    rec.count = ERR_SMALL;
                end else if (n_phase <= PH_HSKIP) begin
                    rec.count = ERR_HDR_LEN;
                end else if (n_phase == PH_TMAGIC || n_phase == PH_TLEN) begin
                    rec.count = ERR_TRK_HDR;
                end else begin
                    rec.count = ERR_TRK_DATA;
                end
                v_recs[v_n[1:0]] = rec;
                v_n = v_n + 3'd1;
            end
            n_phase = PH_MAGIC; n_cbi = '0;   n_fbs = '0;   n_hleft = '0;
            n_fmt = '0;         n_div = '0;   n_ttot = '0;  n_tdone = '0;
            n_tleft = '0;       n_tick = '0;  n_vlq = '0;   n_vlqn = '0;
            n_rs = '0;          n_es = '0;    n_meta = '0;  n_pend = '0;
            n_pleft = '0;       n_edelta = '0;
        end

        o_batch.recs = v_recs;
        o_batch.nrec = v_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_cbi <= '0;   r_fbs <= '0;   r_hleft <= '0;
            r_fmt <= '0;         r_div <= '0;   r_ttot <= '0;  r_tdone <= '0;
            r_tleft <= '0;       r_tick <= '0;  r_vlq <= '0;   r_vlqn <= '0;
            r_rs <= '0;          r_es <= '0;    r_meta <= '0;  r_pend <= '0;
            r_pleft <= '0;       r_edelta <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;  r_cbi <= n_cbi;   r_fbs <= n_fbs;   r_hleft <= n_hleft;
            r_fmt <= n_fmt;      r_div <= n_div;   r_ttot <= n_ttot; r_tdone <= n_tdone;
            r_tleft <= n_tleft;  r_tick <= n_tick; r_vlq <= n_vlq;   r_vlqn <= n_vlqn;
            r_rs <= n_rs;        r_es <= n_es;     r_meta <= n_meta; r_pend <= n_pend;
            r_pleft <= n_pleft;  r_edelta <= n_edelta;
        end
    end

endmodule

>>> rtl/midi_file_stream_parser.sv
`timescale 1ns / 1ps
// Channel  Dir  Words                      Payload
// i_in     in   one file byte per word     byte_value, end_of_file
// o_out    out  one record per word        record_kind .. time_division, run_end
//
// Each accepted byte is parsed in the cycle it is taken; its zero to three records are
// latched into a small record buffer and leave one per cycle while o_out is ready. The
// buffer drain is what sets the rate. Reset is synchronous and active low and returns
// the parser to the start of a file with an empty buffer. A stall on o_out holds the
// current record and, while any record is still waiting, holds i_in as well.
module midi_file_stream_parser import mfsp_pkg::*; #(
    parameter int VLQ_MAX_BYTES = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mfsp_in_if.sink    i_in,
    mfsp_out_if.source o_out
);

    t_batch              w_batch;
    t_rec [MAX_RECS-1:0] r_buf;
    logic [2:0]          r_left;
    logic [1:0]          r_idx;
    logic                w_in_acc;
    logic                w_out_acc;
    t_rec                w_cur;

    // A new byte may enter when the buffer is empty or its last record leaves now.
    assign i_in.ready = (r_left == 3'd0) || (r_left == 3'd1 && o_out.ready);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;

    mfsp_parser #(
        .VLQ_MAX_BYTES(VLQ_MAX_BYTES)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (w_in_acc),
        .i_byte (i_in.byte_value),
        .i_eof  (i_in.end_of_file),
        .o_batch(w_batch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (w_in_acc) begin
            r_left <= w_batch.nrec;
            r_idx  <= '0;
        end else if (w_out_acc) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_buf <= w_batch.recs;
        end
    end

    assign w_cur               = r_buf[r_idx];
    assign o_out.valid         = (r_left != 3'd0);
    assign o_out.run_end       = (r_left == 3'd1);
    assign o_out.record_kind   = w_cur.kind;
    assign o_out.track_number  = w_cur.track;
    assign o_out.tick_time     = w_cur.tick;
    assign o_out.delta_ticks   = w_cur.delta;
    assign o_out.status_byte   = w_cur.status;
    assign o_out.meta_kind     = w_cur.meta;
    assign o_out.first_data    = w_cur.d1;
    assign o_out.second_data   = w_cur.d2;
    assign o_out.count_or_code = w_cur.count;
    assign o_out.file_format   = w_cur.fmt;
    assign o_out.time_division = w_cur.div;

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'(MAX_RECS))
        else $error("record buffer count out of range");

    a_batch_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_batch.nrec != 3'd0) |=> o_out.valid)
        else $error("records of an accepted byte not presented");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left > 3'd1) |-> !i_in.ready)
        else $error("byte accepted over pending records");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.record_kind <= KIND_DONE))
        else $error("record kind out of range");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mfsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 240;

    // Parser phases of the predictor; they follow the walk through a file.
    typedef enum logic [4:0] {
        P_MAGIC, P_HLEN, P_HWORDS, P_HSKIP, P_TMAGIC, P_TLEN, P_DELTA, P_STATUS,
        P_METATYPE, P_METALEN, P_SXLEN, P_DATA1, P_DATA2, P_PAYLOAD, P_DONE, P_ERROR
    } t_phase;

    // One file byte as it goes over the input channel.
    typedef struct {
        logic [7:0] b;
        logic       eof;
    } t_file_word;

    // One predicted record together with its end-of-run marker.
    typedef struct {
        t_rec rec;
        logic last;
    } t_expect_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mfsp_in_if  in_ch ();
    mfsp_out_if out_ch ();

    midi_file_stream_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    t_file_word  file_words[$];
    t_expect_rec expected_recs[$];
    int          mismatches = 0;
    int          cycles = 0;

    // Predictor state: a software copy of the parser.
    t_phase      ph;
    int          idx;
    int          seen;
    logic [31:0] hdr_left;
    logic [15:0] fmt_w, div_w, trk_total, trk_done;
    logic [31:0] trk_left, tick_sum;
    logic [27:0] vlq_acc, ev_delta;
    int          vlq_n;
    logic [7:0]  run_status, ev_status, meta_c, held_data;
    logic [31:0] pay_left;
    t_rec        step_recs[4];
    int          step_n;

    function automatic void clear_parser();
        ph = P_MAGIC;
        idx = 0;
        seen = 0;
        hdr_left = '0;
        fmt_w = '0;
        div_w = '0;
        trk_total = '0;
        trk_done = '0;
        trk_left = '0;
        tick_sum = '0;
        vlq_acc = '0;
        vlq_n = 0;
        run_status = '0;
        ev_status = '0;
        meta_c = '0;
        held_data = '0;
        pay_left = '0;
        ev_delta = '0;
    endfunction

    // A fifth record in one step overwrites the fourth; the parser would wrap to the first slot.
    function automatic int add_rec(logic [3:0] k);
        int i;
        if (step_n < 4) begin
            i = step_n;
            step_n++;
        end else begin
            i = 3;
        end
        step_recs[i] = '0;
        step_recs[i].kind = k;
        return i;
    endfunction

    function automatic int event_rec(logic [3:0] k);
        int i;
        i = add_rec(k);
        step_recs[i].track = trk_done;
        step_recs[i].tick = tick_sum;
        step_recs[i].delta = ev_delta;
        step_recs[i].status = ev_status;
        return i;
    endfunction

    function automatic void raise_error(logic [31:0] code);
        int i;
        i = add_rec(KIND_ERROR);
        step_recs[i].track = trk_done;
        step_recs[i].count = code;
        ph = P_ERROR;
    endfunction

    function automatic void close_file();
        int i;
        i = add_rec(KIND_DONE);
        step_recs[i].count = {16'd0, trk_total};
        ph = P_DONE;
    endfunction

    function automatic void close_track();
        int i;
        i = add_rec(KIND_TRKEND);
        step_recs[i].track = trk_done;
        step_recs[i].tick = tick_sum;
        trk_done = trk_done + 16'd1;
        if (trk_done == trk_total) begin
            close_file();
        end else begin
            ph = P_TMAGIC;
            idx = 0;
            trk_left = '0;
        end
    endfunction

    function automatic void close_header();
        int i;
        i = add_rec(KIND_HEADER);
        step_recs[i].count = {16'd0, trk_total};
        step_recs[i].fmt = fmt_w;
        step_recs[i].div = div_w;
        if (trk_total == 16'd0) begin
            close_file();
        end else begin
            ph = P_TMAGIC;
            idx = 0;
        end
    endfunction

    // Returns 1 when the number is complete, 0 when more follows, -1 when too long.
    function automatic int vlq_step(logic [7:0] b);
        vlq_acc = {vlq_acc[20:0], b[6:0]};
        vlq_n++;
        if (!b[7]) return 1;
        return (vlq_n >= 4) ? -1 : 0;
    endfunction

    function automatic void emit_channel(logic [7:0] second);
        int i;
        i = event_rec(KIND_CHANNEL);
        step_recs[i].d1 = held_data;
        step_recs[i].d2 = second;
        ph = P_DELTA;
        vlq_acc = '0;
        vlq_n = 0;
    endfunction

    function automatic void after_data1();
        if (ev_status[7:4] == 4'hC || ev_status[7:4] == 4'hD) emit_channel(8'h00);
        else ph = P_DATA2;
    endfunction

    function automatic void begin_payload(logic [31:0] len);
        pay_left = len;
        if (len == 0) begin
            ph = P_DELTA;
            vlq_acc = '0;
            vlq_n = 0;
        end else begin
            ph = P_PAYLOAD;
        end
    endfunction

    function automatic void take_status(logic [7:0] b);
        logic [31:0] len;
        int i;
        if (b < 8'h80) begin
            if (run_status == 8'h00) begin
                raise_error(ERR_NO_RUNNING);
                return;
            end
            ev_status = run_status;
            held_data = b;
            after_data1();
            return;
        end
        ev_status = b;
        if (b == 8'hFF) begin
            ph = P_METATYPE;
            return;
        end
        if (b == 8'hF0 || b == 8'hF7) begin
            vlq_acc = '0;
            vlq_n = 0;
            ph = P_SXLEN;
            return;
        end
        if (b[7:4] <= 4'hE) begin
            run_status = b;
            ph = P_DATA1;
            return;
        end
        // System common and realtime messages cancel running status.
        run_status = 8'h00;
        len = (b == 8'hF1 || b == 8'hF3) ? 32'd1 : (b == 8'hF2 ? 32'd2 : 32'd0);
        if (len > trk_left) begin
            raise_error(ERR_SYSTEM);
            return;
        end
        i = event_rec(KIND_SYSTEM);
        step_recs[i].count = len;
        begin_payload(len);
    endfunction

    function automatic void take_length(logic [7:0] b, bit is_meta);
        logic [31:0] code;
        int v;
        int i;
        code = is_meta ? ERR_META_LEN : ERR_SYSEX_LEN;
        v = vlq_step(b);
        if (v < 0) begin
            raise_error(code);
            return;
        end
        if (v == 0) return;
        if ({4'd0, vlq_acc} > trk_left) begin
            raise_error(code);
            return;
        end
        i = event_rec(is_meta ? KIND_META : KIND_SYSEX);
        step_recs[i].count = {4'd0, vlq_acc};
        if (is_meta) step_recs[i].meta = meta_c;
        begin_payload({4'd0, vlq_acc});
    endfunction

    function automatic void take_body(logic [7:0] b);
        int v;
        int i;
        trk_left = trk_left - 32'd1;
        case (ph)
            P_DELTA: begin
                v = vlq_step(b);
                if (v < 0) begin
                    raise_error(ERR_DELTA);
                    return;
                end
                if (v > 0) begin
                    ev_delta = vlq_acc;
                    tick_sum = tick_sum + {4'd0, ev_delta};
                    vlq_acc = '0;
                    vlq_n = 0;
                    ph = P_STATUS;
                end
            end
            P_STATUS: take_status(b);
            P_METATYPE: begin
                meta_c = b;
                vlq_acc = '0;
                vlq_n = 0;
                ph = P_METALEN;
            end
            P_METALEN: take_length(b, 1'b1);
            P_SXLEN: take_length(b, 1'b0);
            P_DATA1: begin
                held_data = b;
                after_data1();
            end
            P_DATA2: emit_channel(b);
            default: begin
                i = event_rec(KIND_PAYLOAD);
                step_recs[i].d1 = b;
                pay_left = pay_left - 32'd1;
                if (pay_left == 0) begin
                    ph = P_DELTA;
                    vlq_acc = '0;
                    vlq_n = 0;
                end
            end
        endcase
        if (ph == P_ERROR || trk_left != 0) return;
        // The last byte of the track: anything still open is an error.
        case (ph)
            P_DELTA: begin
                if (vlq_n == 0) close_track();
                else raise_error(ERR_DELTA);
            end
            P_STATUS: raise_error(ERR_END_DELTA);
            P_METATYPE: raise_error(ERR_META_TYPE);
            P_METALEN: raise_error(ERR_META_LEN);
            P_SXLEN: raise_error(ERR_SYSEX_LEN);
            P_DATA1: raise_error(ERR_DATA1);
            P_DATA2: raise_error(ERR_DATA2);
            default: raise_error(ERR_TRK_DATA);
        endcase
    endfunction

    function automatic void take_file_byte(logic [7:0] b);
        logic [7:0] magic;
        case (ph)
            P_MAGIC: begin
                magic = (idx == 0) ? 8'h4D : (idx == 1) ? 8'h54 : (idx == 2) ? 8'h68 : 8'h64;
                if (b != magic) begin
                    raise_error(ERR_NO_MTHD);
                    return;
                end
                idx++;
                if (idx == 4) begin
                    idx = 0;
                    hdr_left = '0;
                    ph = P_HLEN;
                end
            end
            P_HLEN: begin
                hdr_left = {hdr_left[23:0], b};
                idx++;
                if (idx == 4) begin
                    idx = 0;
                    if (hdr_left < 6) begin
                        raise_error(ERR_HDR_LEN);
                        return;
                    end
                    hdr_left = hdr_left - 32'd6;
                    ph = P_HWORDS;
                end
            end
            P_HWORDS: begin
                if (idx < 2) fmt_w = {fmt_w[7:0], b};
                else if (idx < 4) trk_total = {trk_total[7:0], b};
                else div_w = {div_w[7:0], b};
                idx++;
                if (idx >= 6) begin
                    idx = 0;
                    if (hdr_left == 0) close_header();
                    else ph = P_HSKIP;
                end
            end
            P_HSKIP: begin
                hdr_left = hdr_left - 32'd1;
                if (hdr_left == 0) close_header();
            end
            P_TMAGIC: begin
                magic = (idx == 0) ? 8'h4D : (idx == 1) ? 8'h54 : (idx == 2) ? 8'h72 : 8'h6B;
                if (b != magic) begin
                    raise_error(ERR_NO_MTRK);
                    return;
                end
                idx++;
                if (idx == 4) begin
                    idx = 0;
                    trk_left = '0;
                    ph = P_TLEN;
                end
            end
            P_TLEN: begin
                trk_left = {trk_left[23:0], b};
                idx++;
                if (idx == 4) begin
                    // Every track starts at tick zero with no running status.
                    idx = 0;
                    tick_sum = '0;
                    run_status = '0;
                    ev_delta = '0;
                    vlq_acc = '0;
                    vlq_n = 0;
                    if (trk_left == 0) close_track();
                    else ph = P_DELTA;
                end
            end
            P_DONE, P_ERROR: ;
            default: take_body(b);
        endcase
    endfunction

    // Works out every record one input byte causes and queues them in order.
    function automatic void predict_records(logic [7:0] b, logic eof);
        t_expect_rec e;
        step_n = 0;
        if (seen < 14) seen++;
        take_file_byte(b);
        if (eof) begin
            if (ph != P_DONE && ph != P_ERROR) begin
                if (seen < 14) raise_error(ERR_SMALL);
                else if (ph <= P_HSKIP) raise_error(ERR_HDR_LEN);
                else if (ph == P_TMAGIC || ph == P_TLEN) raise_error(ERR_TRK_HDR);
                else raise_error(ERR_TRK_DATA);
            end
            clear_parser();
        end
        for (int k = 0; k < step_n; k++) begin
            e.rec = step_recs[k];
            e.last = (k == step_n - 1);
            expected_recs.insert(expected_recs.size(), e);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // ---------------- Stimulus construction ----------------

    function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    // Appends a delta or length number in n bytes; leading 0x80 bytes pad it out.
    function automatic void put_vlq(ref logic [7:0] q[$], input logic [27:0] v, input int n);
        for (int k = n - 1; k >= 0; k--)
            add_byte(q, {(k > 0), 7'(v >> (7 * k))});
    endfunction

    function automatic int vlq_size(logic [27:0] v);
        if (v < 28'h80) return 1;
        if (v < 28'h4000) return 2;
        if (v < 28'h200000) return 3;
        return 4;
    endfunction

    function automatic void put_be32(ref logic [7:0] q[$], input logic [31:0] v);
        for (int k = 3; k >= 0; k--) add_byte(q, v[8 * k +: 8]);
    endfunction

    // Builds one track body. Mostly well formed, with a few broken events mixed in.
    function automatic void build_track(ref logic [7:0] q[$], input int nev, input bit huge);
        logic [7:0] rs, st;
        logic [27:0] d;
        int sel, len, n;
        rs = 8'h00;
        for (int e = 0; e < nev; e++) begin
            if (huge) begin
                // Largest deltas, so the tick counter wraps within the track.
                put_vlq(q, 28'hFFFFFFF, 4);
                add_byte(q, 8'hC0 | 8'($urandom_range(0, 15)));
                add_byte(q, 8'($urandom_range(0, 127)));
                continue;
            end
            n = $urandom_range(1, 4);
            d = ($urandom_range(0, 3) == 0) ? 28'd0 : 28'($urandom) & ((28'd1 << (7 * n)) - 1);
            sel = $urandom_range(0, 19);
            if (sel == 16) begin
                // Continuation bit still set on the fourth delta byte.
                for (int k = 0; k < 4; k++) add_byte(q, 8'h80 | 8'($urandom_range(0, 127)));
                continue;
            end
            put_vlq(q, d, vlq_size(d) + (($urandom_range(0, 7) == 0) ? 1 : 0) > 4 ?
                    4 : vlq_size(d) + (($urandom_range(0, 7) == 0) ? 1 : 0));
            if (sel == 15 && rs == 8'h00) begin
                add_byte(q, 8'($urandom_range(0, 127)));
            end else if (sel <= 7 || sel >= 15) begin
                if (rs == 8'h00 || sel >= 3) begin
                    st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
                    add_byte(q, st);
                    rs = st;
                end
                add_byte(q, 8'($urandom_range(0, 127)));
                if (rs[7:4] != 4'hC && rs[7:4] != 4'hD) add_byte(q, 8'($urandom_range(0, 127)));
            end else if (sel <= 12) begin
                len = $urandom_range(0, 5);
                if (sel <= 10) begin
                    add_byte(q, 8'hFF);
                    add_byte(q, 8'($urandom));
                end else begin
                    add_byte(q, ($urandom_range(0, 1) != 0) ? 8'hF0 : 8'hF7);
                end
                put_vlq(q, 28'(len), $urandom_range(1, 2));
                for (int k = 0; k < len; k++) add_byte(q, 8'($urandom));
            end else begin
                case ($urandom_range(0, 5))
                    0: st = 8'hF1;
                    1: st = 8'hF2;
                    2: st = 8'hF3;
                    3: st = 8'hF6;
                    4: st = 8'hF8;
                    default: st = 8'hFE;
                endcase
                add_byte(q, st);
                len = (st == 8'hF1 || st == 8'hF3) ? 1 : (st == 8'hF2 ? 2 : 0);
                for (int k = 0; k < len; k++) add_byte(q, 8'($urandom));
                rs = 8'h00;
            end
        end
    endfunction

    function automatic void queue_file(ref logic [7:0] q[$]);
        t_file_word w;
        for (int k = 0; k < q.size(); k++) begin
            w.b = q[k];
            w.eof = (k == q.size() - 1);
            file_words.insert(file_words.size(), w);
        end
    endfunction

    // A whole file: header, tracks, maybe trailing bytes, maybe one defect.
    function automatic int build_file(bit huge);
        logic [7:0] f[$], t[$];
        int ntr, extra, adj, cut;
        ntr = huge ? 1 : (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        f = '{8'h4D, 8'h54, 8'h68, 8'h64};
        put_be32(f, 32'(6 + extra));
        add_byte(f, 8'($urandom));
        add_byte(f, 8'($urandom));
        add_byte(f, 8'h00);
        add_byte(f, 8'(ntr));
        add_byte(f, 8'($urandom));
        add_byte(f, 8'($urandom));
        for (int k = 0; k < extra; k++) add_byte(f, 8'($urandom));
        for (int tr = 0; tr < ntr; tr++) begin
            t.delete();
            build_track(t, huge ? 18 : $urandom_range(0, 5), huge);
            adj = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) - 3 : 0;
            if (t.size() + adj < 0) adj = 0;
            add_byte(f, 8'h4D);
            add_byte(f, 8'h54);
            add_byte(f, 8'h72);
            add_byte(f, 8'h6B);
            put_be32(f, 32'(t.size() + adj));
            foreach (t[k]) add_byte(f, t[k]);
        end
        if ($urandom_range(0, 3) == 0)
            for (int k = $urandom_range(1, 3); k > 0; k--) add_byte(f, 8'($urandom));
        if (!huge) begin
            case ($urandom_range(0, 9))
                0: f[$urandom_range(0, f.size() - 1)] = 8'($urandom);
                1: begin
                    cut = $urandom_range(1, f.size());
                    while (f.size() > cut) void'(f.pop_back());
                end
                default: ;
            endcase
        end
        queue_file(f);
        return f.size();
    endfunction

    // ---------------- Input driver ----------------

    bit         in_taken = 0;
    bit         in_busy = 0;
    int         in_gap = 0;
    bit         in_calm = 0;
    t_file_word in_word;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken = 0;
                in_busy = 0;
                if ($urandom_range(0, 31) == 0) in_calm = ~in_calm;
                in_gap = in_calm ? 0 : $urandom_range(0, 4);
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (file_words.size() > 0) begin
                    in_word = file_words.pop_front();
                    in_busy = 1;
                end
            end
            in_ch.valid <= in_busy;
            in_ch.byte_value <= in_word.b;
            in_ch.end_of_file <= in_word.eof;
        end
    end

    // ---------------- Output sink ----------------

    bit out_taken = 0;
    int out_stall = 0;
    bit out_calm = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                out_taken = 0;
                if ($urandom_range(0, 31) == 0) out_calm = ~out_calm;
                out_stall = out_calm ? 0 : $urandom_range(0, 4);
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------- Monitor ----------------

    always @(posedge i_clk) begin
        t_expect_rec e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_records(in_ch.byte_value, in_ch.end_of_file);
                in_taken = 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                out_taken = 1;
                if (expected_recs.size() == 0) begin
                    $error("record kind %0d arrived with none expected", out_ch.record_kind);
                    mismatches++;
                end else begin
                    e = expected_recs.pop_front();
                    check_field("record_kind", 32'(e.rec.kind), 32'(out_ch.record_kind));
                    check_field("run_end", 32'(e.last), 32'(out_ch.run_end));
                    check_field("track_number", 32'(e.rec.track), 32'(out_ch.track_number));
                    check_field("tick_time", e.rec.tick, out_ch.tick_time);
                    check_field("delta_ticks", 32'(e.rec.delta), 32'(out_ch.delta_ticks));
                    check_field("status_byte", 32'(e.rec.status), 32'(out_ch.status_byte));
                    check_field("meta_kind", 32'(e.rec.meta), 32'(out_ch.meta_kind));
                    check_field("first_data", 32'(e.rec.d1), 32'(out_ch.first_data));
                    check_field("second_data", 32'(e.rec.d2), 32'(out_ch.second_data));
                    check_field("count_or_code", e.rec.count, out_ch.count_or_code);
                    check_field("file_format", 32'(e.rec.fmt), 32'(out_ch.file_format));
                    check_field("time_division", 32'(e.rec.div), 32'(out_ch.time_division));
                end
            end
        end
    end

    // ---------------- Sequence ----------------

    initial begin
        logic [7:0] f[$];
        int total;
        in_ch.valid = 1'b0;
        in_ch.byte_value = 8'h00;
        in_ch.end_of_file = 1'b0;
        out_ch.ready = 1'b0;
        clear_parser();

        // Directed: a file cut short, a wrong first byte, and a header length below six.
        f = '{8'h4D, 8'h54, 8'h68};
        queue_file(f);
        f = '{8'hFF, 8'h00};
        queue_file(f);
        f = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00};
        queue_file(f);
        // Header only, zero tracks, with bytes after the done record.
        f = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
              8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
        queue_file(f);

        // Random files; the first one drives the tick counter through its wrap.
        total = build_file(1'b1);
        while (total < RANDOM_WORDS) total += build_file(1'b0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (file_words.size() > 0 || in_busy || expected_recs.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_recs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mfsp_pkg.sv
rtl/mfsp_if.sv
rtl/mfsp_parser.sv
rtl/midi_file_stream_parser.sv
tb/testbench.sv
